// ===== design/gbb_pkg.sv =====
// shared types, constants and helpers of the glyph bitmap blitter
`default_nettype none
package gbb_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    FMT_MONO8    = 2'd0,
    FMT_MONO1    = 2'd1,
    FMT_AA2      = 2'd2,
    FMT_DISABLED = 2'd3
  } pix_fmt_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_ROTATION     = 2'd1,
    REG_PIXEL_COLOR  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] ALPHA_MID  = 8'd192;
  localparam logic [7:0] ALPHA_LOW  = 8'd100;
  localparam logic [7:0] ALPHA_NONE = 8'd0;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic       we;
    logic       blend;
    logic [7:0] alpha;
  } pixel_t;

  // coverage of one antialiased pixel pair
  function automatic logic [7:0] aa_alpha(input logic [1:0] pair);
    logic [7:0] a;
    case (pair)
      2'b11:   a = ALPHA_FULL;
      2'b10:   a = ALPHA_MID;
      2'b01:   a = ALPHA_LOW;
      default: a = ALPHA_NONE;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/gbb_if.sv =====
// item channels of the glyph bitmap blitter
`default_nettype none
interface gbb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_glyph;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [7:0]  glyph_width;
  logic [7:0]  glyph_height;

  modport source (output valid, data_byte, first_of_glyph, origin_x, origin_y,
                  glyph_width, glyph_height, input ready);
  modport sink (input valid, data_byte, first_of_glyph, origin_x, origin_y,
                glyph_width, glyph_height, output ready);
endinterface

interface gbb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic        write_enable;
  logic        blend_mode;
  logic [7:0]  alpha;
  logic        last;

  modport source (output valid, pixel_x, pixel_y, write_enable, blend_mode, alpha,
                  last, input ready);
  modport sink (input valid, pixel_x, pixel_y, write_enable, blend_mode, alpha,
                last, output ready);
endinterface
`default_nettype wire

// ===== design/gbb_pixel_unit.sv =====
// decodes one pixel of a bitmap byte and places it after rotation
`default_nettype none
module gbb_pixel_unit (
  input  wire logic [7:0]     data_byte,
  input  wire logic [2:0]     pix_idx,
  input  wire gbb_pkg::pix_fmt_t fmt,
  input  wire gbb_pkg::rot_t  rot,
  input  wire gbb_pkg::coord_t org_x,
  input  wire gbb_pkg::coord_t org_y,
  input  wire logic [7:0]     col,
  input  wire logic [7:0]     row,
  output gbb_pkg::pixel_t     pix
);
  import gbb_pkg::*;

  logic [7:0] mono_sh;
  logic [7:0] aa_sh;
  coord_t     col_ext;
  coord_t     row_ext;

  assign mono_sh = data_byte << pix_idx;
  assign aa_sh   = data_byte << {pix_idx[1:0], 1'b0};
  assign col_ext = coord_t'(col);
  assign row_ext = coord_t'(row);

  always_comb begin
    case (fmt)
      FMT_MONO8: begin
        pix.we    = (data_byte != 8'd0);
        pix.blend = 1'b0;
        pix.alpha = ALPHA_FULL;
      end
      FMT_AA2: begin
        pix.we    = (aa_sh[7:6] != 2'b00);
        pix.blend = 1'b1;
        pix.alpha = aa_alpha(aa_sh[7:6]);
      end
      default: begin
        pix.we    = mono_sh[7];
        pix.blend = 1'b0;
        pix.alpha = ALPHA_FULL;
      end
    endcase

    case (rot)
      ROT_0: begin
        pix.x = org_x + col_ext;
        pix.y = org_y + row_ext;
      end
      ROT_90: begin
        pix.x = org_x - row_ext;
        pix.y = org_y + col_ext;
      end
      ROT_180: begin
        pix.x = org_x - col_ext;
        pix.y = org_y - row_ext;
      end
      default: begin
        pix.x = org_x + row_ext;
        pix.y = org_y - col_ext;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/glyph_bitmap_blitter.sv =====
// top level of the glyph bitmap blitter
// Takes packed glyph bitmap bytes on in_ch and sends one pixel item per pixel
// position on out_ch: 1 item per byte in 8-bit mono, up to 4 in 2-bit
// antialiased and up to 8 in 1-bit mono, fewer when the glyph ends inside the
// byte, none for padding after the glyph, for an empty glyph or when the format
// is disabled. The pixel unpacker issues one pixel item per cycle while the
// output register is free; a byte holds the input until its last pixel is
// issued (one yielding nothing is dropped at once), and the next byte is
// taken in the cycle its last pixel goes out, so 8-bit bytes stream at 1 per
// cycle unless the output stalls. A finished pixel sits in the output register
// while the unpacker works on the next one. first_of_glyph latches origin and
// size and restarts the column/row position; last marks the final pixel of
// each byte. Registers are written on cfg_we while the block is idle, a rule
// for the user that the block does not enforce; pixel_color is stored but drives no output.
`default_nettype none
module glyph_bitmap_blitter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  gbb_in_if.sink                                  in_ch,
  gbb_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [gbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [gbb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import gbb_pkg::*;

  // configuration
  pix_fmt_t fmt_r;
  rot_t     rot_r;
  logic [CFG_DATA_BITS-1:0] color_r;

  // glyph state
  coord_t     org_x_r, org_x_nxt;
  coord_t     org_y_r, org_y_nxt;
  logic [7:0] cols_r, cols_nxt;
  logic [7:0] rows_r, rows_nxt;
  logic [7:0] col_cnt_r, col_cnt_nxt;
  logic [7:0] row_cnt_r, row_cnt_nxt;

  // byte being unpacked
  logic       byte_valid_r, byte_valid_nxt;
  logic [7:0] byte_r;
  logic [2:0] idx_r, idx_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  pixel_t     out_pix_r;
  logic       out_last_r;

  pixel_t     pix;
  logic [2:0] last_idx;
  logic       glyph_done;
  logic       skip;
  logic       out_free;
  logic       emit;
  logic       col_wrap;
  logic       glyph_end;
  logic       pix_last;
  logic       byte_done;
  logic       in_ready;
  logic       accept;

  // pixels per byte, minus one
  always_comb begin
    case (fmt_r)
      FMT_MONO8: last_idx = 3'd0;
      FMT_AA2:   last_idx = 3'd3;
      default:   last_idx = 3'd7;
    endcase
  end

  gbb_pixel_unit u_pixel (
    .data_byte (byte_r),
    .pix_idx   (idx_r),
    .fmt       (fmt_r),
    .rot       (rot_r),
    .org_x     (org_x_r),
    .org_y     (org_y_r),
    .col       (col_cnt_r),
    .row       (row_cnt_r),
    .pix       (pix)
  );

  // glyph finished (or never started) means the byte yields nothing more
  assign glyph_done = (cols_r == 8'd0) || (rows_r == 8'd0) || (row_cnt_r >= rows_r);
  assign skip       = (fmt_r == FMT_DISABLED) || glyph_done;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit       = byte_valid_r && !skip && out_free;

  assign col_wrap  = ({1'b0, col_cnt_r} + 9'd1) >= {1'b0, cols_r};
  assign glyph_end = col_wrap && (({1'b0, row_cnt_r} + 9'd1) >= {1'b0, rows_r});
  assign pix_last  = (idx_r == last_idx) || glyph_end;

  assign byte_done = byte_valid_r && (skip || (emit && pix_last));
  assign in_ready  = !byte_valid_r || byte_done;
  assign accept    = in_ch.valid && in_ready;

  assign in_ch.ready = in_ready;

  always_comb begin
    org_x_nxt      = org_x_r;
    org_y_nxt      = org_y_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    col_cnt_nxt    = col_cnt_r;
    row_cnt_nxt    = row_cnt_r;
    idx_nxt        = idx_r;
    byte_valid_nxt = byte_valid_r;

    // walk the pixel position
    if (emit) begin
      idx_nxt = idx_r + 3'd1;
      if (col_wrap) begin
        col_cnt_nxt = 8'd0;
        row_cnt_nxt = row_cnt_r + 8'd1;
      end else begin
        col_cnt_nxt = col_cnt_r + 8'd1;
      end
    end

    if (byte_done) begin
      byte_valid_nxt = 1'b0;
    end

    // a new glyph restarts after the previous byte has finished
    if (accept) begin
      byte_valid_nxt = 1'b1;
      idx_nxt        = 3'd0;
      if (in_ch.first_of_glyph) begin
        org_x_nxt   = coord_t'(in_ch.origin_x);
        org_y_nxt   = coord_t'(in_ch.origin_y);
        cols_nxt    = in_ch.glyph_width;
        rows_nxt    = in_ch.glyph_height;
        col_cnt_nxt = 8'd0;
        row_cnt_nxt = 8'd0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= FMT_MONO1;
      rot_r        <= ROT_0;
      color_r      <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      cols_r       <= 8'd0;
      rows_r       <= 8'd0;
      col_cnt_r    <= 8'd0;
      row_cnt_r    <= 8'd0;
      idx_r        <= 3'd0;
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PIXEL_FORMAT: fmt_r   <= pix_fmt_t'(cfg_wdata[1:0]);
          REG_ROTATION:     rot_r   <= rot_t'(cfg_wdata[1:0]);
          REG_PIXEL_COLOR:  color_r <= cfg_wdata;
          default: ;
        endcase
      end
      org_x_r      <= org_x_nxt;
      org_y_r      <= org_y_nxt;
      cols_r       <= cols_nxt;
      rows_r       <= rows_nxt;
      col_cnt_r    <= col_cnt_nxt;
      row_cnt_r    <= row_cnt_nxt;
      idx_r        <= idx_nxt;
      byte_valid_r <= byte_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.data_byte;
    end
    if (emit) begin
      out_pix_r  <= pix;
      out_last_r <= pix_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = 16'(out_pix_r.x);
  assign out_ch.pixel_y      = 16'(out_pix_r.y);
  assign out_ch.write_enable = out_pix_r.we;
  assign out_ch.blend_mode   = out_pix_r.blend;
  assign out_ch.alpha        = out_pix_r.alpha;
  assign out_ch.last         = out_last_r;

`ifndef NO_ASSERTIONS
  // the column counter never reaches the latched width
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cols_r != 8'd0) |-> (col_cnt_r < cols_r))
    else $error("column counter beyond glyph width");

  // nothing leaves while the format is disabled
  a_no_emit_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (fmt_r == FMT_DISABLED) |-> !emit)
    else $error("pixel issued with format disabled");

  // a byte still holding pixels blocks the input
  a_hold_busy_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid_r && !byte_done) |-> !in_ch.ready)
    else $error("new byte taken while pixels remain");

  // an issued pixel never lies past the glyph
  a_emit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (row_cnt_r < rows_r))
    else $error("pixel issued past glyph end");
`endif

endmodule
`default_nettype wire
